[sv/bbp_pkg.sv]
`default_nettype none

package bbp_pkg;

   typedef enum logic [2:0] {
      CSR_RED_MASK    = 3'd0,
      CSR_GREEN_MASK  = 3'd1,
      CSR_BLUE_MASK   = 3'd2,
      CSR_BYTES_PIXEL = 3'd3,
      CSR_USE_FIELDS  = 3'd4,
      CSR_OUT_ORDER   = 3'd5
   } csr_index_type;

   localparam logic [31:0] RED_MASK_555   = 32'h0000_7C00;
   localparam logic [31:0] GREEN_MASK_555 = 32'h0000_03E0;
   localparam logic [31:0] BLUE_MASK_555  = 32'h0000_001F;
   localparam logic [31:0] RED_MASK_888   = 32'h00FF_0000;
   localparam logic [31:0] GREEN_MASK_888 = 32'h0000_FF00;
   localparam logic [31:0] BLUE_MASK_888  = 32'h0000_00FF;

   localparam logic [2:0] BPP_RESET   = 3'd4;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // scale by 255/(2^n-1) as a multiply by ceil(2^25/(2^n-1)) and a shift
   localparam int unsigned RECIP_SHIFT = 25;
   localparam int unsigned RECIP_BITS  = 26;

   typedef struct packed {
      logic [31:0] pixel_word;
      logic        pixel_present;
   } pixel_in_type;

   typedef struct packed {
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
      logic [7:0] out_byte3;
      logic       format_error;
   } pixel_out_type;

   typedef struct packed {
      logic       ok;
      logic [4:0] shift;
      logic [3:0] width;
   } chan_info_type;

   function automatic logic [RECIP_BITS-1:0] scale_recip(input logic [3:0] width);
      logic [RECIP_BITS-1:0] r;
      unique case (width)
         4'd1:    r = 26'd33554432;
         4'd2:    r = 26'd11184811;
         4'd3:    r = 26'd4793491;
         4'd4:    r = 26'd2236963;
         4'd5:    r = 26'd1082402;
         4'd6:    r = 26'd532611;
         4'd7:    r = 26'd264209;
         4'd8:    r = 26'd131587;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/bbp_mask_decode.sv]
`default_nettype none

module bbp_mask_decode
   import bbp_pkg::*;
#(
   parameter int unsigned MAX_CHANNEL_BITS = 8
) (
   input  wire logic [31:0]   mask,
   output chan_info_type      info
);

   logic [31:0] low_bit;
   logic [31:0] carry_sum;
   logic [4:0]  shift;
   logic [31:0] mask_sh;
   logic [3:0]  width;
   logic        contiguous;
   logic        narrow;

   always_comb begin
      low_bit   = mask & (~mask + 32'd1);
      // a contiguous run plus its lowest bit leaves none of the run set
      carry_sum = mask + low_bit;
      contiguous = (carry_sum & mask) == 32'd0;
      for (int k = 0; k < 5; k++) begin
         shift[k] = 1'b0;
         for (int i = 0; i < 32; i++) begin
            if (((i >> k) & 1) == 1) begin
               shift[k] = shift[k] | low_bit[i];
            end
         end
      end
      mask_sh = mask >> shift;
      narrow  = (mask_sh >> MAX_CHANNEL_BITS) == 32'd0 && mask_sh[31:8] == 24'd0;
      width   = 4'd0;
      for (int i = 0; i < 8; i++) begin
         width = width + {3'd0, mask_sh[i]};
      end
      info.ok    = (mask != 32'd0) && contiguous && narrow;
      info.shift = shift;
      info.width = width;
   end

endmodule

`default_nettype wire

[sv/bbp_chan_scale.sv]
`default_nettype none

module bbp_chan_scale
   import bbp_pkg::*;
(
   input  wire logic [31:0]   word,
   input  wire chan_info_type info,
   output logic [7:0]         value
);

   logic [31:0]                      word_sh;
   logic [7:0]                       field_mask;
   logic [7:0]                       field;
   logic [15:0]                      times_255;
   logic [16+RECIP_BITS-1:0]         product;

   always_comb begin
      word_sh = word >> info.shift;
      for (int i = 0; i < 8; i++) begin
         field_mask[i] = (4'(i) < info.width);
      end
      field     = word_sh[7:0] & field_mask;
      times_255 = {field, 8'h00} - {8'h00, field};
      product   = (16+RECIP_BITS)'(times_255) * (16+RECIP_BITS)'(scale_recip(info.width));
      value     = product[RECIP_SHIFT+7:RECIP_SHIFT];
   end

endmodule

`default_nettype wire

[sv/bmp_bitfield_pixel_to_rgba8.sv]
`default_nettype none

// the result strobe leaves the result register, which follows the input register; one pixel
// per cycle throughput, busy never rises (mask decode before the input register, field
// extract and scale before the result register)
// reset: synchronous, restores the default masks, 4 bytes per pixel, fixed masks,
// b,g,r,a order, and drops any pixel in flight; the receiver cannot stall
module bmp_bitfield_pixel_to_rgba8
   import bbp_pkg::*;
#(
   parameter int unsigned MAX_CHANNEL_BITS = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire pixel_in_type  req_data,
   output logic               rsp_valid,
   output pixel_out_type      rsp_data,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [31:0]   csr_wdata
);

   logic [31:0]   red_mask_ff, green_mask_ff, blue_mask_ff;
   logic [2:0]    bpp_ff;
   logic          use_fields_ff;
   logic          order_ff;

   logic          accept;
   logic          bpp_two, bpp_three;
   logic [31:0]   word_in;
   logic [31:0]   red_sel, green_sel, blue_sel;
   chan_info_type red_info, green_info, blue_info;

   logic          stg_valid_ff;
   logic [31:0]   word_ff;
   chan_info_type red_info_ff, green_info_ff, blue_info_ff;
   logic          stg_order_ff;

   logic [7:0]    red_val, green_val, blue_val;
   logic          fmt_ok;
   logic [7:0]    red_out, green_out, blue_out;
   pixel_out_type rsp_in;
   pixel_out_type rsp_ff;
   logic          rsp_valid_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         red_mask_ff   <= RED_MASK_888;
         green_mask_ff <= GREEN_MASK_888;
         blue_mask_ff  <= BLUE_MASK_888;
         bpp_ff        <= BPP_RESET;
         use_fields_ff <= 1'b0;
         order_ff      <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RED_MASK:    red_mask_ff   <= csr_wdata;
            CSR_GREEN_MASK:  green_mask_ff <= csr_wdata;
            CSR_BLUE_MASK:   blue_mask_ff  <= csr_wdata;
            CSR_BYTES_PIXEL: bpp_ff        <= csr_wdata[2:0];
            CSR_USE_FIELDS:  use_fields_ff <= csr_wdata[0];
            CSR_OUT_ORDER:   order_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pixel size saturates to 2..4
   always_comb begin
      bpp_two   = bpp_ff < 3'd3;
      bpp_three = bpp_ff == 3'd3;
      if (!req_data.pixel_present) begin
         word_in = 32'd0;
      end else if (bpp_two) begin
         word_in = {16'd0, req_data.pixel_word[15:0]};
      end else if (bpp_three) begin
         word_in = {8'd0, req_data.pixel_word[23:0]};
      end else begin
         word_in = req_data.pixel_word;
      end
      if (use_fields_ff) begin
         red_sel   = red_mask_ff;
         green_sel = green_mask_ff;
         blue_sel  = blue_mask_ff;
      end else if (bpp_two) begin
         red_sel   = RED_MASK_555;
         green_sel = GREEN_MASK_555;
         blue_sel  = BLUE_MASK_555;
      end else begin
         red_sel   = RED_MASK_888;
         green_sel = GREEN_MASK_888;
         blue_sel  = BLUE_MASK_888;
      end
   end

   bbp_mask_decode #(.MAX_CHANNEL_BITS(MAX_CHANNEL_BITS)) u_red_dec (
      .mask (red_sel),
      .info (red_info)
   );

   bbp_mask_decode #(.MAX_CHANNEL_BITS(MAX_CHANNEL_BITS)) u_green_dec (
      .mask (green_sel),
      .info (green_info)
   );

   bbp_mask_decode #(.MAX_CHANNEL_BITS(MAX_CHANNEL_BITS)) u_blue_dec (
      .mask (blue_sel),
      .info (blue_info)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff       <= word_in;
         red_info_ff   <= red_info;
         green_info_ff <= green_info;
         blue_info_ff  <= blue_info;
         stg_order_ff  <= order_ff;
      end
   end

   bbp_chan_scale u_red_scale (
      .word  (word_ff),
      .info  (red_info_ff),
      .value (red_val)
   );

   bbp_chan_scale u_green_scale (
      .word  (word_ff),
      .info  (green_info_ff),
      .value (green_val)
   );

   bbp_chan_scale u_blue_scale (
      .word  (word_ff),
      .info  (blue_info_ff),
      .value (blue_val)
   );

   always_comb begin
      fmt_ok    = red_info_ff.ok && green_info_ff.ok && blue_info_ff.ok;
      red_out   = fmt_ok ? red_val   : 8'd0;
      green_out = fmt_ok ? green_val : 8'd0;
      blue_out  = fmt_ok ? blue_val  : 8'd0;
      rsp_in.out_byte0    = stg_order_ff ? red_out : blue_out;
      rsp_in.out_byte1    = green_out;
      rsp_in.out_byte2    = stg_order_ff ? blue_out : red_out;
      rsp_in.out_byte3    = ((red_out | green_out | blue_out) != 8'd0) ? ALPHA_OPAQUE : 8'd0;
      rsp_in.format_error = !fmt_ok;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_beat_reaches_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("accepted beat did not produce a result");

   a_error_zero_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.format_error |->
         rsp_data.out_byte0 == 8'd0 && rsp_data.out_byte1 == 8'd0 &&
         rsp_data.out_byte2 == 8'd0 && rsp_data.out_byte3 == 8'd0)
      else $error("format error with nonzero bytes");

   a_alpha_matches_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.out_byte3 == ALPHA_OPAQUE) ==
         ((rsp_data.out_byte0 | rsp_data.out_byte1 | rsp_data.out_byte2) != 8'd0))
      else $error("alpha disagrees with color bytes");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(stg_valid_ff))
      else $error("result strobe without a staged beat");
`endif

endmodule

`default_nettype wire

[tb/bmp_bitfield_pixel_to_rgba8_checker.sv]
module bmp_bitfield_pixel_to_rgba8_checker
   import bbp_pkg::*;
#(
   parameter int unsigned MAX_CHANNEL_BITS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          busy,
   input  pixel_in_type  req_data,
   input  logic          rsp_valid,
   input  pixel_out_type rsp_data,
   input  logic          csr_valid,
   input  logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_wdata,
   output int            pending,
   output int            fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       ok;
      logic [7:0] level;
   } channel_level_type;

   logic [31:0] cfg_red_mask;
   logic [31:0] cfg_green_mask;
   logic [31:0] cfg_blue_mask;
   logic [2:0]  cfg_bpp;
   logic        cfg_use_fields;
   logic        cfg_order;

   pixel_out_type expected_pixels[$];
   pixel_out_type want;

   initial begin
      pending = 0;
      fail_count = 0;
   end

   function automatic channel_level_type decode_channel(input logic [31:0] mask,
                                                        input logic [31:0] word);
      channel_level_type res;
      int unsigned       sh;
      int unsigned       n;
      logic [31:0]       m;
      logic [31:0]       m_inc;
      logic [31:0]       full;
      logic [31:0]       v;
      logic [31:0]       scaled;
      res = '0;
      m = mask;
      sh = 0;
      if (m == 32'd0) return res;
      while (m[0] == 1'b0 && sh < 31) begin
         m = m >> 1;
         sh++;
      end
      m_inc = m + 32'd1;
      if ((m & m_inc) != 32'd0) return res;
      n = 0;
      while (n < 32 && m[n]) n++;
      if (n > MAX_CHANNEL_BITS || n > 8) return res;
      full = (32'd1 << n) - 32'd1;
      v = (word >> sh) & m;
      scaled = (v * 32'd255) / full;
      res.ok = 1'b1;
      res.level = scaled[7:0];
      return res;
   endfunction

   function automatic pixel_out_type unpack_pixel(input pixel_in_type px);
      pixel_out_type     res;
      int unsigned       size;
      logic [31:0]       word;
      logic [31:0]       rm;
      logic [31:0]       gm;
      logic [31:0]       bm;
      channel_level_type r;
      channel_level_type g;
      channel_level_type b;
      logic              ok;
      size = (cfg_bpp < 3'd2) ? 2 : ((cfg_bpp > 3'd4) ? 4 : int'(cfg_bpp));
      word = px.pixel_word;
      if (!px.pixel_present) word = 32'd0;
      else if (size == 2) word &= 32'h0000_FFFF;
      else if (size == 3) word &= 32'h00FF_FFFF;
      if (cfg_use_fields) begin
         rm = cfg_red_mask;
         gm = cfg_green_mask;
         bm = cfg_blue_mask;
      end else if (size == 2) begin
         rm = RED_MASK_555;
         gm = GREEN_MASK_555;
         bm = BLUE_MASK_555;
      end else begin
         rm = RED_MASK_888;
         gm = GREEN_MASK_888;
         bm = BLUE_MASK_888;
      end
      r = decode_channel(rm, word);
      g = decode_channel(gm, word);
      b = decode_channel(bm, word);
      ok = r.ok && g.ok && b.ok;
      if (!ok) begin
         r.level = 8'd0;
         g.level = 8'd0;
         b.level = 8'd0;
      end
      res.out_byte0 = cfg_order ? r.level : b.level;
      res.out_byte1 = g.level;
      res.out_byte2 = cfg_order ? b.level : r.level;
      res.out_byte3 = ((r.level | g.level | b.level) != 8'd0) ? ALPHA_OPAQUE : 8'd0;
      res.format_error = !ok;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [7:0] exp_val,
                              input logic [7:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s expected %0d got %0d", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_pixels.delete();
         cfg_red_mask = RED_MASK_888;
         cfg_green_mask = GREEN_MASK_888;
         cfg_blue_mask = BLUE_MASK_888;
         cfg_bpp = BPP_RESET;
         cfg_use_fields = 1'b0;
         cfg_order = 1'b0;
      end else begin
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               $error("result beat with no pixel outstanding");
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("out_byte0", want.out_byte0, rsp_data.out_byte0);
               check_field("out_byte1", want.out_byte1, rsp_data.out_byte1);
               check_field("out_byte2", want.out_byte2, rsp_data.out_byte2);
               check_field("out_byte3", want.out_byte3, rsp_data.out_byte3);
               check_field("format_error", {7'd0, want.format_error},
                           {7'd0, rsp_data.format_error});
            end
         end
         if (start && !busy) expected_pixels.push_back(unpack_pixel(req_data));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RED_MASK:    cfg_red_mask = csr_wdata;
               CSR_GREEN_MASK:  cfg_green_mask = csr_wdata;
               CSR_BLUE_MASK:   cfg_blue_mask = csr_wdata;
               CSR_BYTES_PIXEL: cfg_bpp = csr_wdata[2:0];
               CSR_USE_FIELDS:  cfg_use_fields = csr_wdata[0];
               CSR_OUT_ORDER:   cfg_order = csr_wdata[0];
               default: ;
            endcase
         end
      end
      pending = expected_pixels.size();
   end

endmodule

[tb/bmp_bitfield_pixel_to_rgba8_test.sv]
module bmp_bitfield_pixel_to_rgba8_test
   import bbp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DRAIN_CYCLES  = 4;
   localparam int unsigned IDLE_PERCENT  = 11;
   localparam int unsigned RANDOM_PHASES = 12;
   localparam int unsigned PHASE_ITEMS   = 100;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   pixel_in_type  req_data = '0;
   logic          rsp_valid;
   pixel_out_type rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [2:0]    csr_index = 3'd0;
   logic [31:0]   csr_wdata = 32'd0;
   int            pending;
   int            fail_count;
   bit            idle_on = 1'b1;
   int            pixels_sent = 0;
   int            settings_used = 0;

   always #4 clock = ~clock;

   bmp_bitfield_pixel_to_rgba8 #(.MAX_CHANNEL_BITS(8)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   bmp_bitfield_pixel_to_rgba8_checker #(.MAX_CHANNEL_BITS(8)) checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .pending(pending), .fail_count(fail_count)
   );

   task automatic send_pixel(input logic [31:0] word, input logic present);
      @(negedge clock);
      while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_data.pixel_word = word;
      req_data.pixel_present = present;
      do @(posedge clock); while (busy);
      pixels_sent++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      @(negedge clock);
      while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // hold off until every pixel has come back, then let the pipe go quiet
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic apply_setting(input logic [31:0] red, input logic [31:0] green,
                                input logic [31:0] blue, input logic [2:0] bpp,
                                input logic fields, input logic order);
      drain();
      write_reg(CSR_RED_MASK, red);
      write_reg(CSR_GREEN_MASK, green);
      write_reg(CSR_BLUE_MASK, blue);
      write_reg(CSR_BYTES_PIXEL, {29'd0, bpp});
      write_reg(CSR_USE_FIELDS, {31'd0, fields});
      write_reg(CSR_OUT_ORDER, {31'd0, order});
      settings_used++;
   endtask

   function automatic logic [31:0] random_mask();
      int unsigned kind;
      int unsigned w;
      int unsigned span;
      int unsigned pos;
      logic [63:0] field;
      kind = $urandom_range(0, 99);
      span = $urandom_range(0, 1) ? 16 : 32;
      if (kind < 78) begin
         // mostly legal widths, some too wide
         w = (kind < 70) ? $urandom_range(1, 8) : $urandom_range(9, 16);
         pos = $urandom_range(0, span - w);
         field = ((64'd1 << w) - 64'd1) << pos;
         return field[31:0];
      end
      if (kind < 86) return 32'd0;
      if (kind < 94) return $urandom;
      if (kind < 97) return 32'hFFFF_FFFF;
      w = $urandom_range(3, 8);
      pos = $urandom_range(0, 32 - w);
      field = (((64'd1 << w) - 64'd1) << pos) & ~(64'd2 << pos);
      return field[31:0];
   endfunction

   initial begin
      logic [31:0] word;
      int unsigned kind;
      logic [2:0]  bpp;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // defaults after reset: fixed 8-8-8, 4 bytes, b,g,r,a
      send_pixel(32'h0000_0000, 1'b1);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel(32'h00FF_0000, 1'b1);
      send_pixel(32'h0000_FF00, 1'b1);
      send_pixel(32'h0000_00FF, 1'b1);
      send_pixel(32'hFF00_0000, 1'b1);

      // fixed 5-5-5, upper half ignored
      apply_setting(RED_MASK_888, GREEN_MASK_888, BLUE_MASK_888, 3'd2, 1'b0, 1'b1);
      send_pixel(32'h0000_7C00, 1'b1);
      send_pixel(32'h0000_03E0, 1'b1);
      send_pixel(32'h0000_001F, 1'b1);
      send_pixel(32'hFFFF_0000, 1'b1);

      apply_setting(RED_MASK_888, GREEN_MASK_888, BLUE_MASK_888, 3'd3, 1'b0, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      send_pixel(32'hFF00_0000, 1'b1);

      // 5-6-5 bitfields
      apply_setting(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 3'd2, 1'b1, 1'b0);
      send_pixel(32'h0000_FFFF, 1'b1);
      send_pixel(32'h0000_0841, 1'b1);

      // zero, non-contiguous and too wide masks; absent pixel still flagged
      apply_setting(32'h0000_0000, 32'h0000_0005, 32'h0000_01FF, 3'd4, 1'b1, 1'b1);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      send_pixel(32'h0000_0000, 1'b0);

      // masks above the pixel size read as zero
      apply_setting(32'hFF00_0000, 32'h8000_0000, 32'h0000_0001, 3'd3, 1'b1, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      send_pixel(32'h0000_0001, 1'b1);

      apply_setting(32'hFFFF_FFFF, GREEN_MASK_888, BLUE_MASK_888, 3'd7, 1'b1, 1'b1);
      send_pixel(32'hFFFF_FFFF, 1'b1);

      // out-of-range sizes saturate
      apply_setting(32'h0000_00F0, 32'h0000_0F00, 32'h0000_0003, 3'd0, 1'b0, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      apply_setting(32'h0000_00F0, 32'h0000_0F00, 32'h0000_0003, 3'd1, 1'b0, 1'b1);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      apply_setting(32'h0000_00F0, 32'h0000_0F00, 32'h0000_0003, 3'd5, 1'b0, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      apply_setting(32'h0000_00F0, 32'h0000_0F00, 32'h0000_0003, 3'd6, 1'b1, 1'b1);
      send_pixel(32'hFFFF_FFFF, 1'b1);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         idle_on = (ph < 4 || ph > 6);
         bpp = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(2, 4))
                                          : 3'($urandom_range(0, 7));
         apply_setting(random_mask(), random_mask(), random_mask(), bpp,
                       $urandom_range(0, 99) < 75, 1'($urandom_range(0, 1)));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            kind = $urandom_range(0, 9);
            word = (kind == 0) ? 32'd0 : ((kind == 1) ? 32'hFFFF_FFFF : $urandom);
            send_pixel(word, $urandom_range(0, 9) != 0);
         end
      end

      idle_on = 1'b1;
      drain();
      $display("ran %0d pixels through %0d register settings: fixed and bitfield masks,",
               pixels_sent, settings_used);
      $display("bad masks, absent pixels, both byte orders and pixel sizes 0 to 7");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule

[sim.f]
sv/bbp_pkg.sv
sv/bbp_mask_decode.sv
sv/bbp_chan_scale.sv
sv/bmp_bitfield_pixel_to_rgba8.sv
tb/bmp_bitfield_pixel_to_rgba8_checker.sv
tb/bmp_bitfield_pixel_to_rgba8_test.sv
